// ===== design/sng_pkg.sv =====
// sng_pkg: shared types, constants and the microprogram for the noise gate
// depends on nothing; used by sng_mul, sng_seq, sng_dp and sensitivity_noise_gate
package sng_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned LevelW  = 40;
  localparam int unsigned GateW   = 25;
  localparam int unsigned SensW   = 17;
  localparam int unsigned OpAW    = 42;
  localparam int unsigned OpBW    = 18;
  localparam int unsigned ProdW   = OpAW + OpBW;
  localparam int unsigned AccW    = 74;
  localparam int unsigned PcW     = 5;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  // decay and step coefficients, q0.32
  localparam logic [31:0] COEF_RELEASE = 32'd4293678806;
  localparam logic [31:0] COEF_PEAK    = 32'd4294924346;
  localparam logic [31:0] COEF_SCALE   = 32'd1503238554;
  localparam logic [31:0] COEF_OPEN    = 32'd42949673;
  localparam logic [31:0] COEF_CLOSE   = 32'd4294967;

  localparam logic [GateW-1:0] GATE_ONE   = 25'd16777216;
  localparam logic [SensW-1:0] SENS_ONE   = 17'd65536;
  localparam logic [SensW-1:0] SENS_RESET = 17'd32768;

  // register word index
  localparam logic [0:0] REG_SENS = 1'b0;

  typedef struct packed {
    logic                      restart;
    logic signed [SampleW-1:0] left_sample;
    logic signed [SampleW-1:0] right_sample;
  } sng_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] gated_left;
    logic signed [SampleW-1:0] gated_right;
    logic [GateW-1:0]          gate_value;
  } sng_out_t;

  typedef enum logic [2:0] {
    A_ENV, A_PEAK, A_THR, A_DIST, A_LEFT, A_RIGHT
  } a_sel_t;

  typedef enum logic [3:0] {
    B_ZERO, B_REL_LO, B_REL_HI, B_PK_LO, B_PK_HI, B_SINV, B_SC_LO, B_SC_HI,
    B_GC_LO, B_GC_HI, B_G_LO, B_G_HI
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_SHLADD
  } acc_op_t;

  typedef enum logic [3:0] {
    WB_NONE, WB_ENV_ATK, WB_ENV, WB_PEAK_RISE, WB_PEAK, WB_THR16, WB_THR32,
    WB_DIST, WB_GATE, WB_OUTL, WB_OUTR
  } wb_t;

  typedef enum logic [1:0] {
    JMP_NONE, JMP_ATTACK, JMP_RISE, JMP_NODIST
  } jmp_t;

  typedef enum logic {
    SEQ_IDLE, SEQ_RUN
  } seq_state_t;

  typedef struct packed {
    a_sel_t         a_sel;
    b_sel_t         b_sel;
    acc_op_t        acc_op;
    wb_t            wb;
    jmp_t           jmp;
    logic [PcW-1:0] target;
    logic           last;
  } sng_ctrl_t;

  typedef struct packed {
    logic attack;
    logic rise;
    logic no_dist;
  } sng_stat_t;

  // jump targets
  localparam logic [PcW-1:0] PC_PEAK  = 5'd4;
  localparam logic [PcW-1:0] PC_THR   = 5'd8;
  localparam logic [PcW-1:0] PC_APPLY = 5'd20;
  localparam logic [PcW-1:0] PC_NONE  = 5'd0;

  function automatic sng_ctrl_t cw(a_sel_t a, b_sel_t b, acc_op_t op, wb_t wb, jmp_t j,
                                   logic [PcW-1:0] tgt, logic last);
    sng_ctrl_t c;
    c.a_sel  = a;
    c.b_sel  = b;
    c.acc_op = op;
    c.wb     = wb;
    c.jmp    = j;
    c.target = tgt;
    c.last   = last;
    return c;
  endfunction

  localparam sng_ctrl_t CTRL_NOP = cw(A_ENV, B_ZERO, ACC_HOLD, WB_NONE, JMP_NONE, PC_NONE, 1'b0);

  // the product issued in one step is consumed by the accumulator in the next
  function automatic sng_ctrl_t sng_rom(logic [PcW-1:0] pc);
    sng_ctrl_t c;
    c = CTRL_NOP;
    case (pc)
      // envelope: attack jumps straight to the peak tracker
      5'd0:  c = cw(A_ENV,   B_REL_LO, ACC_HOLD,   WB_ENV_ATK,   JMP_ATTACK, PC_PEAK, 1'b0);
      5'd1:  c = cw(A_ENV,   B_REL_HI, ACC_LOAD,   WB_NONE,      JMP_NONE,   PC_NONE, 1'b0);
      5'd2:  c = cw(A_ENV,   B_ZERO,   ACC_SHLADD, WB_NONE,      JMP_NONE,   PC_NONE, 1'b0);
      5'd3:  c = cw(A_ENV,   B_ZERO,   ACC_HOLD,   WB_ENV,       JMP_NONE,   PC_NONE, 1'b0);
      // peak tracker
      5'd4:  c = cw(A_PEAK,  B_PK_LO,  ACC_HOLD,   WB_PEAK_RISE, JMP_RISE,   PC_THR,  1'b0);
      5'd5:  c = cw(A_PEAK,  B_PK_HI,  ACC_LOAD,   WB_NONE,      JMP_NONE,   PC_NONE, 1'b0);
      5'd6:  c = cw(A_PEAK,  B_ZERO,   ACC_SHLADD, WB_NONE,      JMP_NONE,   PC_NONE, 1'b0);
      5'd7:  c = cw(A_PEAK,  B_ZERO,   ACC_HOLD,   WB_PEAK,      JMP_NONE,   PC_NONE, 1'b0);
      // threshold = ((peak * (1 - sens)) >> 16) * 0.35
      5'd8:  c = cw(A_PEAK,  B_SINV,   ACC_HOLD,   WB_NONE,      JMP_NONE,   PC_NONE, 1'b0);
      5'd9:  c = cw(A_PEAK,  B_ZERO,   ACC_LOAD,   WB_NONE,      JMP_NONE,   PC_NONE, 1'b0);
      5'd10: c = cw(A_PEAK,  B_ZERO,   ACC_HOLD,   WB_THR16,     JMP_NONE,   PC_NONE, 1'b0);
      5'd11: c = cw(A_THR,   B_SC_LO,  ACC_HOLD,   WB_NONE,      JMP_NONE,   PC_NONE, 1'b0);
      5'd12: c = cw(A_THR,   B_SC_HI,  ACC_LOAD,   WB_NONE,      JMP_NONE,   PC_NONE, 1'b0);
      5'd13: c = cw(A_THR,   B_ZERO,   ACC_SHLADD, WB_NONE,      JMP_NONE,   PC_NONE, 1'b0);
      5'd14: c = cw(A_THR,   B_ZERO,   ACC_HOLD,   WB_THR32,     JMP_NONE,   PC_NONE, 1'b0);
      // gate level: step toward target, skipped when already there
      5'd15: c = cw(A_DIST,  B_ZERO,   ACC_HOLD,   WB_DIST,      JMP_NONE,   PC_NONE, 1'b0);
      5'd16: c = cw(A_DIST,  B_GC_LO,  ACC_HOLD,   WB_NONE,      JMP_NODIST, PC_APPLY, 1'b0);
      5'd17: c = cw(A_DIST,  B_GC_HI,  ACC_LOAD,   WB_NONE,      JMP_NONE,   PC_NONE, 1'b0);
      5'd18: c = cw(A_DIST,  B_ZERO,   ACC_SHLADD, WB_NONE,      JMP_NONE,   PC_NONE, 1'b0);
      5'd19: c = cw(A_DIST,  B_ZERO,   ACC_HOLD,   WB_GATE,      JMP_NONE,   PC_NONE, 1'b0);
      // apply gate to both channels
      5'd20: c = cw(A_LEFT,  B_G_LO,   ACC_HOLD,   WB_NONE,      JMP_NONE,   PC_NONE, 1'b0);
      5'd21: c = cw(A_LEFT,  B_G_HI,   ACC_LOAD,   WB_NONE,      JMP_NONE,   PC_NONE, 1'b0);
      5'd22: c = cw(A_RIGHT, B_G_LO,   ACC_SHLADD, WB_NONE,      JMP_NONE,   PC_NONE, 1'b0);
      5'd23: c = cw(A_RIGHT, B_G_HI,   ACC_LOAD,   WB_OUTL,      JMP_NONE,   PC_NONE, 1'b0);
      5'd24: c = cw(A_RIGHT, B_ZERO,   ACC_SHLADD, WB_NONE,      JMP_NONE,   PC_NONE, 1'b0);
      5'd25: c = cw(A_RIGHT, B_ZERO,   ACC_HOLD,   WB_OUTR,      JMP_NONE,   PC_NONE, 1'b0);
      5'd26: c = cw(A_ENV,   B_ZERO,   ACC_HOLD,   WB_NONE,      JMP_NONE,   PC_NONE, 1'b1);
      default: c = CTRL_NOP;
    endcase
    return c;
  endfunction

endpackage

// ===== design/sng_mul.sv =====
// sng_mul: shared signed multiplier with a registered product
// depends on sng_pkg for operand widths
module sng_mul (
  input  logic                             clk,
  input  logic signed [sng_pkg::OpAW-1:0]  op_a,
  input  logic signed [sng_pkg::OpBW-1:0]  op_b,
  output logic signed [sng_pkg::ProdW-1:0] prod_r
);
  import sng_pkg::*;

  logic signed [ProdW-1:0] prod_nxt;

  assign prod_nxt = ProdW'(op_a) * ProdW'(op_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ===== design/sng_seq.sv =====
// sng_seq: microcode sequencer, step counter, program rom and conditional jumps
// depends on sng_pkg for the control word, status and program
module sng_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               stall,
  input  sng_pkg::sng_stat_t stat,
  output sng_pkg::sng_ctrl_t ctrl,
  output logic               busy,
  output logic               done
);
  import sng_pkg::*;

  seq_state_t     state_r, state_nxt;
  logic [PcW-1:0] pc_r, pc_nxt;
  sng_ctrl_t      rom_word;
  logic           taken;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  assign rom_word = sng_rom(pc_r);

  always_comb begin
    case (rom_word.jmp)
      JMP_ATTACK: taken = stat.attack;
      JMP_RISE:   taken = stat.rise;
      JMP_NODIST: taken = stat.no_dist;
      default:    taken = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    ctrl      = CTRL_NOP;
    busy      = 1'b1;
    done      = 1'b0;
    unique case (state_r)
      SEQ_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_nxt = SEQ_RUN;
          pc_nxt    = '0;
        end
      end
      SEQ_RUN: begin
        ctrl = rom_word;
        if (rom_word.last) begin
          // final step waits here until the output register is free
          if (!stall) begin
            done      = 1'b1;
            state_nxt = SEQ_IDLE;
          end
        end else begin
          pc_nxt = taken ? rom_word.target : pc_r + 1'b1;
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

endmodule

// ===== design/sng_dp.sv =====
// sng_dp: datapath with envelope, peak, threshold and gate registers around one multiplier
// depends on sng_pkg and sng_mul
module sng_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  sng_pkg::sng_in_t             item,
  input  logic [sng_pkg::SensW-1:0]    sensitivity,
  input  sng_pkg::sng_ctrl_t           ctrl,
  output sng_pkg::sng_stat_t           stat,
  output sng_pkg::sng_out_t            res
);
  import sng_pkg::*;

  logic [LevelW-1:0]         env_r, env_nxt, peak_r, peak_nxt, thr_r, thr_nxt;
  logic [GateW-1:0]          gate_r, gate_nxt, dist_r, dist_nxt, step;
  logic                      open_r, open_nxt;
  logic signed [SampleW-1:0] left_r, right_r, gl_r, gl_nxt, gr_r, gr_nxt;
  logic [SampleW-1:0]        mag_r;
  logic [LevelW-1:0]         mag_lvl;
  logic signed [AccW-1:0]    acc_r, acc_nxt, prod_ext;
  logic signed [OpAW-1:0]    op_a;
  logic signed [OpBW-1:0]    op_b;
  logic signed [ProdW-1:0]   prod;
  logic [SensW-1:0]          sens_inv;
  logic [31:0]               gate_coef;
  logic [47:0]               rnd;

  sng_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r  <= '0;
      peak_r <= '0;
      gate_r <= '0;
    end else begin
      env_r  <= env_nxt;
      peak_r <= peak_nxt;
      gate_r <= gate_nxt;
    end
  end

  always_ff @(posedge clk) begin
    thr_r  <= thr_nxt;
    dist_r <= dist_nxt;
    open_r <= open_nxt;
    acc_r  <= acc_nxt;
    gl_r   <= gl_nxt;
    gr_r   <= gr_nxt;
    if (start) begin
      left_r  <= item.left_sample;
      right_r <= item.right_sample;
      mag_r   <= item.left_sample[SampleW-1] ? $unsigned(~item.left_sample + 1'b1)
                                             : $unsigned(item.left_sample);
    end
  end

  assign mag_lvl   = {mag_r, 16'b0};
  assign sens_inv  = (sensitivity > SENS_ONE) ? '0 : SENS_ONE - sensitivity;
  assign gate_coef = open_r ? COEF_OPEN : COEF_CLOSE;
  assign prod_ext  = AccW'(prod);
  // ceiling of the q0.32 product
  assign step      = acc_r[56:32] + {24'b0, |acc_r[31:0]};
  assign rnd       = acc_r[47:0] + 48'h800000;

  assign stat.attack  = mag_lvl > env_r;
  assign stat.rise    = env_r > peak_r;
  assign stat.no_dist = (dist_r == '0);

  always_comb begin
    unique case (ctrl.a_sel)
      A_ENV:   op_a = $signed({2'b0, env_r});
      A_PEAK:  op_a = $signed({2'b0, peak_r});
      A_THR:   op_a = $signed({2'b0, thr_r});
      A_DIST:  op_a = $signed({17'b0, dist_r});
      A_LEFT:  op_a = OpAW'(left_r);
      A_RIGHT: op_a = OpAW'(right_r);
      default: op_a = '0;
    endcase
  end

  always_comb begin
    unique case (ctrl.b_sel)
      B_REL_LO: op_b = $signed({2'b0, COEF_RELEASE[15:0]});
      B_REL_HI: op_b = $signed({2'b0, COEF_RELEASE[31:16]});
      B_PK_LO:  op_b = $signed({2'b0, COEF_PEAK[15:0]});
      B_PK_HI:  op_b = $signed({2'b0, COEF_PEAK[31:16]});
      B_SINV:   op_b = $signed({1'b0, sens_inv});
      B_SC_LO:  op_b = $signed({2'b0, COEF_SCALE[15:0]});
      B_SC_HI:  op_b = $signed({2'b0, COEF_SCALE[31:16]});
      B_GC_LO:  op_b = $signed({2'b0, gate_coef[15:0]});
      B_GC_HI:  op_b = $signed({2'b0, gate_coef[31:16]});
      B_G_LO:   op_b = $signed({2'b0, gate_r[15:0]});
      B_G_HI:   op_b = $signed({9'b0, gate_r[24:16]});
      default:  op_b = '0;
    endcase
  end

  always_comb begin
    unique case (ctrl.acc_op)
      ACC_LOAD:   acc_nxt = prod_ext;
      ACC_SHLADD: acc_nxt = acc_r + (prod_ext <<< 16);
      default:    acc_nxt = acc_r;
    endcase
  end

  always_comb begin
    env_nxt  = env_r;
    peak_nxt = peak_r;
    gate_nxt = gate_r;
    thr_nxt  = thr_r;
    dist_nxt = dist_r;
    open_nxt = open_r;
    gl_nxt   = gl_r;
    gr_nxt   = gr_r;
    if (start && item.restart) begin
      env_nxt  = '0;
      peak_nxt = '0;
      gate_nxt = '0;
    end
    unique case (ctrl.wb)
      WB_ENV_ATK: begin
        if (stat.attack) begin
          env_nxt = mag_lvl;
        end
      end
      WB_ENV: env_nxt = acc_r[71:32];
      WB_PEAK_RISE: begin
        if (stat.rise) begin
          peak_nxt = env_r;
        end
      end
      WB_PEAK:  peak_nxt = acc_r[71:32];
      WB_THR16: thr_nxt  = acc_r[55:16];
      WB_THR32: thr_nxt  = acc_r[71:32];
      WB_DIST: begin
        open_nxt = env_r > thr_r;
        dist_nxt = (env_r > thr_r) ? GATE_ONE - gate_r : gate_r;
      end
      WB_GATE: gate_nxt = open_r ? gate_r + step : gate_r - step;
      WB_OUTL: gl_nxt   = $signed(rnd[47:24]);
      WB_OUTR: gr_nxt   = $signed(rnd[47:24]);
      default: ;
    endcase
  end

  assign res.gated_left  = gl_r;
  assign res.gated_right = gr_r;
  assign res.gate_value  = gate_r;

endmodule

// ===== design/sensitivity_noise_gate.sv =====
// sensitivity_noise_gate: top level with handshakes, config register and output register
// depends on sng_pkg, sng_seq and sng_dp
//
// Adaptive noise gate, one stereo frame per item. The input channel (in_valid, in_ready,
// in_data) takes restart and the two q1.23 samples; the output channel (out_valid,
// out_ready, out_data) returns both gated samples and the q1.24 gate level, one result
// per item, in order.
// Each item runs through a 27-step microprogram on a single shared multiplier; the
// sequencer walks the program and skips the release, peak decay or gate step
// multiplies when the envelope attacks, the peak rises or the gate is already at its
// target. The block accepts one item at a time: in_ready is high again the cycle after
// the result is loaded, so a new item is taken while the previous result waits in the
// output register. If out_ready stays low the sequencer parks on its final step and
// in_ready stays low until the output register frees up.
// Sensitivity (q1.16, 17 bits) is written through the apb port at byte address 0 and
// reads back from the same address; values above 1.0 act as 1.0.
// Reset (rst_n low, synchronous) clears envelope, peak, gate level and the output
// valid, and sets sensitivity to 0.5.
module sensitivity_noise_gate (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  sng_pkg::sng_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output sng_pkg::sng_out_t            out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sng_pkg::AddrW-1:0]    paddr,
  input  logic [sng_pkg::DataW-1:0]    pwdata,
  output logic [sng_pkg::DataW-1:0]    prdata,
  output logic                         pready
);
  import sng_pkg::*;

  logic [SensW-1:0] sens_r, sens_nxt;
  logic             out_valid_r, out_valid_nxt;
  sng_out_t         out_data_r, out_data_nxt;
  logic             start, stall, busy, done, sens_wr;
  sng_ctrl_t        ctrl;
  sng_stat_t        stat;
  sng_out_t         res;

  sng_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stall (stall),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy),
    .done  (done)
  );

  sng_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .item        (in_data),
    .sensitivity (sens_r),
    .ctrl        (ctrl),
    .stat        (stat),
    .res         (res)
  );

  assign in_ready = !busy;
  assign start    = in_valid && in_ready;
  assign stall    = out_valid_r && !out_ready;

  assign sens_wr  = psel && penable && pwrite && (paddr[AddrW-1:2] == REG_SENS);
  assign sens_nxt = sens_wr ? pwdata[SensW-1:0] : sens_r;
  assign prdata   = (paddr[AddrW-1:2] == REG_SENS) ? {{(DataW-SensW){1'b0}}, sens_r} : '0;
  assign pready   = 1'b1;

  assign out_valid_nxt = done || (out_valid_r && !out_ready);
  assign out_data_nxt  = done ? res : out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r      <= SENS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      sens_r      <= sens_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_ready)
    else $error("sequencer did not leave idle after an item was taken");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (!out_valid_r || out_ready))
    else $error("result loaded over an unread output");

  a_gate_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.gate_value <= GATE_ONE))
    else $error("gate level above fully open");
`endif

endmodule
